[rtl/hsf_pkg.sv]
// Package for the heading slug filter: transaction types, character codes,
// register indexes and the UTF-8 lead byte decoder. No dependencies.
package hsf_pkg;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HIGH_BIT   = 8'h80;
    localparam logic [7:0] CH_CASE_BIT   = 8'h20;

    // Configuration register indexes and reset values.
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_MAX_LENGTH = 1'b0;
    localparam logic [9:0]  MAX_LENGTH_RST = 10'd511;

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // One input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_final;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0] slug_byte;
        logic       has_byte;
        logic       slug_done;
    } t_out_item;

    // Command from the classifier to the emitter.
    typedef struct packed {
        logic [7:0] slug_byte;
        logic       send_dash;
        logic       send_byte;
        logic       done;
    } t_cmd;

    // Number of continuation bytes announced by a UTF-8 lead byte.
    function automatic logic [1:0] follow_count(input logic [7:0] lead);
        logic [1:0] cnt;
        cnt = 2'd0;
        if (lead[7:5] == 3'b110)
            cnt = 2'd1;
        else if (lead[7:4] == 4'b1110)
            cnt = 2'd2;
        else if (lead[7:3] == 5'b11110)
            cnt = 2'd3;
        return cnt;
    endfunction

endpackage

[rtl/heading_slug_filter.sv]
// Top level of the heading slug filter: configuration register, front
// classifier, command queue and back emitter. Depends on hsf_pkg and hsf_*.
//
// Usage: heading text enters one byte per transaction on the push/full side
// (i_in_item: text_byte and is_final). Slug bytes leave on the empty/pop side
// (o_out_item: slug_byte, has_byte, slug_done), oldest first. A byte emitted
// after a held hyphen yields two results, the hyphen first. A final byte that
// emits nothing yields one result with has_byte low and slug_done high.
// The first result of an accepted byte passes through the command queue and
// then the output register before it can be taken. The front takes one byte
// per cycle while full is low; the back delivers one result per cycle while
// the receiver pops, so a byte that brings a hyphen with it yields two results
// in the back, and a four-entry command queue absorbs those bursts.
// When the receiver stalls, the output register holds its result, the queue
// fills, and full rises; no transaction is lost.
// Reset is synchronous and clears all string state, empties the queue and
// sets max_length (APB byte address 0) to 511. Write max_length only while
// the block is idle.
module heading_slug_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input queue side
    input  logic                           push,
    output logic                           full,
    input  hsf_pkg::t_in_item              i_in_item,
    // Result queue side
    output logic                           empty,
    input  logic                           pop,
    output hsf_pkg::t_out_item             o_out_item,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hsf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import hsf_pkg::*;

    logic [9:0] r_max_length;
    logic       cfg_write;
    logic       in_accept;
    logic       cmd_push;
    t_cmd       cmd_in;
    logic       cmdq_valid;
    t_cmd       cmdq_cmd;
    logic       cmdq_pop;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_MAX_LENGTH);
    assign prdata    = (paddr[2] == REG_MAX_LENGTH) ? {22'd0, r_max_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (cfg_write) begin
            r_max_length <= pwdata[9:0];
        end
    end

    assign in_accept = push && !full;

    hsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_max_length (r_max_length),
        .o_cmd_valid  (cmd_push),
        .o_cmd        (cmd_in)
    );

    hsf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmdq_pop),
        .o_full  (full),
        .o_valid (cmdq_valid),
        .o_cmd   (cmdq_cmd)
    );

    hsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmdq_valid),
        .i_cmd       (cmdq_cmd),
        .o_cmd_pop   (cmdq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

[rtl/hsf_front.sv]
// Front part of the heading slug filter: classifies each input byte and
// turns those that emit or end a string into commands. Depends on hsf_pkg.
module hsf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hsf_pkg::t_in_item   i_item,
    input  logic [9:0]          i_max_length,
    output logic                o_cmd_valid,
    output hsf_pkg::t_cmd       o_cmd
);
    import hsf_pkg::*;

    logic       r_after_dash, n_after_dash;
    logic       r_dash_held,  n_dash_held;
    logic [1:0] r_cont_left,  n_cont_left;
    logic [9:0] r_bytes_written, n_bytes_written;

    logic [7:0] c;
    logic       emit;
    logic [7:0] emit_byte;

    assign c = i_item.text_byte;

    // Classify the byte and work out the next string state.
    always_comb begin
        emit            = 1'b0;
        emit_byte       = c;
        n_after_dash    = r_after_dash;
        n_dash_held     = r_dash_held;
        n_cont_left     = r_cont_left;
        n_bytes_written = r_bytes_written;

        if (r_bytes_written < i_max_length) begin
            if (r_cont_left != 2'd0) begin
                n_cont_left = r_cont_left - 2'd1;
                emit        = 1'b1;
            end else if (c >= CH_HIGH_BIT) begin
                n_cont_left = follow_count(c);
                emit        = 1'b1;
            end else if (c >= 8'h41 && c <= 8'h5A) begin
                emit_byte = c | CH_CASE_BIT;
                emit      = 1'b1;
            end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39)
                         || c == CH_UNDERSCORE) begin
                emit = 1'b1;
            end else if (c == CH_DASH || c == CH_SPACE) begin
                if (!r_after_dash) begin
                    n_bytes_written = r_bytes_written + 10'd1;
                    n_dash_held     = 1'b1;
                    n_after_dash    = 1'b1;
                end
            end
            if (emit) begin
                n_bytes_written = r_bytes_written + 10'd1;
                n_dash_held     = 1'b0;
                n_after_dash    = 1'b0;
            end
        end else begin
            n_cont_left = 2'd0;
        end

        // The end of a string returns all string state to its start.
        if (i_item.is_final) begin
            n_after_dash    = 1'b1;
            n_dash_held     = 1'b0;
            n_cont_left     = 2'd0;
            n_bytes_written = 10'd0;
        end
    end

    // Command toward the back part.
    always_comb begin
        o_cmd_valid     = i_accept && (emit || i_item.is_final);
        o_cmd.slug_byte = emit ? emit_byte : 8'd0;
        o_cmd.send_dash = emit && r_dash_held;
        o_cmd.send_byte = emit;
        o_cmd.done      = i_item.is_final;
    end

    // String state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_dash    <= 1'b1;
            r_dash_held     <= 1'b0;
            r_cont_left     <= 2'd0;
            r_bytes_written <= 10'd0;
        end else if (i_accept) begin
            r_after_dash    <= n_after_dash;
            r_dash_held     <= n_dash_held;
            r_cont_left     <= n_cont_left;
            r_bytes_written <= n_bytes_written;
        end
    end

endmodule

[rtl/hsf_cmdq.sv]
// Short command queue between front and back of the heading slug filter.
// Depends on hsf_pkg.
module hsf_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hsf_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output hsf_pkg::t_cmd  o_cmd
);
    import hsf_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_PTR_W:0]   r_count,  n_count;
    logic                  do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and level update.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(do_pop);
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_cmd;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/hsf_back.sv]
// Back part of the heading slug filter: expands commands into result
// transactions and holds them in the output register. Depends on hsf_pkg.
module hsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  hsf_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output hsf_pkg::t_out_item o_item
);
    import hsf_pkg::*;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic      r_pend_done, n_pend_done;
    logic      out_free;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_item   = r_out;

    // Pick the next result: a byte left behind a hyphen, else a new command.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_done  = r_pend_done;
        o_cmd_pop    = 1'b0;
        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_pend_valid) begin
                n_out_valid     = 1'b1;
                n_out.slug_byte = r_pend_byte;
                n_out.has_byte  = 1'b1;
                n_out.slug_done = r_pend_done;
                n_pend_valid    = 1'b0;
            end else if (i_cmd_valid) begin
                o_cmd_pop   = 1'b1;
                n_out_valid = 1'b1;
                if (i_cmd.send_dash) begin
                    n_out.slug_byte = CH_DASH;
                    n_out.has_byte  = 1'b1;
                    n_out.slug_done = 1'b0;
                    n_pend_valid    = 1'b1;
                    n_pend_byte     = i_cmd.slug_byte;
                    n_pend_done     = i_cmd.done;
                end else begin
                    n_out.slug_byte = i_cmd.slug_byte;
                    n_out.has_byte  = i_cmd.send_byte;
                    n_out.slug_done = i_cmd.done;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pend_byte <= n_pend_byte;
        r_pend_done <= n_pend_done;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // A byte waits behind a hyphen only while that hyphen is on the output.
    a_pend_has_dash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid && r_out.has_byte && !r_out.slug_done
                         && r_out.slug_byte == CH_DASH)
        else $error("pending byte without a hyphen on the output");

    // A result without a byte only ever closes a string, and carries zero.
    a_empty_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.has_byte |-> r_out.slug_done && r_out.slug_byte == 8'd0)
        else $error("empty result that does not end a string");

    // No new command is taken while a byte still waits behind a hyphen.
    a_no_pop_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !o_cmd_pop)
        else $error("command taken while a byte was pending");

endmodule
